>>> rtl/core/bpjq_pkg.sv
package bpjq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int CAP_W = 5;
    localparam int KEY_W = 25;
    localparam logic [7:0] CASE_BIT = 8'h20;

    localparam logic CFG_CAPACITY = 1'b0;
    localparam logic CFG_SHUT_DOWN = 1'b1;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_PUSHED = 3'd0,
        ST_POPPED = 3'd1,
        ST_FULL   = 3'd2,
        ST_EMPTY  = 3'd3,
        ST_SHUT   = 3'd4
    } status_t;

    typedef struct packed {
        logic [15:0] chan;
        logic [7:0]  ltr;
        logic        hseq;
        logic [15:0] seqv;
    } tag_t;

    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctrl_t;

    // channel, then inverted letter, then no-sequence
    function automatic logic [KEY_W-1:0] tag_key(input tag_t t);
        tag_key = {t.chan, ~t.ltr, ~t.hseq};
    endfunction

endpackage

>>> rtl/core/bounded_priority_job_queue.sv
// bounded priority queue of job tags
// command channel: start with operation, channel, letter, has_sequence and
// sequence_req; a transfer happens at a rising edge with start high and busy low
// busy never rises, so one command may be given in every cycle
// result channel: result_valid marks one cycle holding status, out_channel,
// out_letter, out_has_sequence, out_sequence and now_empty
// latency: the result shows in the cycle after the command transfer
// throughput: one command per cycle; every cell of the sorted row compares its
// tag to the new one in parallel and shifts by one place toward its neighbor
// config port: cfg_we, cfg_index, cfg_data; index 0 capacity_limit, index 1
// shut_down; a write takes effect at the edge where cfg_we is high
// reset: the queue is empty, capacity_limit is 16, shut_down is 0,
// no result is shown
// the receiver cannot stall: each result is valid for exactly one cycle
module bounded_priority_job_queue
    import bpjq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             operation,
    input  logic [15:0]      channel,
    input  logic [7:0]       letter,
    input  logic             has_sequence,
    input  logic [15:0]      sequence_req,
    output logic             result_valid,
    output logic [2:0]       status,
    output logic [15:0]      out_channel,
    output logic [7:0]       out_letter,
    output logic             out_has_sequence,
    output logic [15:0]      out_sequence,
    output logic             now_empty,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CAP_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CAP_W-1:0] capacity_reg;
    logic             shut_reg;
    logic             result_valid_reg;
    status_t          status_reg;
    status_t          status_next;
    tag_t             out_tag_reg;
    tag_t             out_tag_next;
    logic             now_empty_reg;

    logic       accept;
    logic       full;
    logic       empty;
    cell_ctrl_t ctrl;
    tag_t       new_tag;
    tag_t       tags [QUEUE_DEPTH];
    logic       ge [QUEUE_DEPTH];

    assign busy = 1'b0;
    assign accept = start && !busy;
    assign empty = (count_reg == '0);
    assign full = (CMP_W'(count_reg) >= CMP_W'(capacity_reg))
               || (count_reg == CNT_W'(QUEUE_DEPTH));

    assign new_tag.chan = channel;
    assign new_tag.ltr = letter & ~CASE_BIT;
    assign new_tag.hseq = has_sequence;
    assign new_tag.seqv = sequence_req;

    always_comb
    begin
        ctrl = '0;
        status_next = ST_SHUT;
        out_tag_next = '0;
        count_next = count_reg;
        if (shut_reg)
        begin
            status_next = ST_SHUT;
        end
        else if (op_t'(operation) == OP_PUSH)
        begin
            if (full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                status_next = ST_PUSHED;
                ctrl.push = accept;
                count_next = count_reg + 1'b1;
            end
        end
        else
        begin
            if (empty)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                status_next = ST_POPPED;
                out_tag_next = tags[0];
                ctrl.pop = accept;
                count_next = count_reg - 1'b1;
            end
        end
    end

    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin : g_cell
            tag_t prev_t;
            tag_t next_t;
            logic prev_g;
            if (i == 0)
            begin : g_first
                assign prev_t = new_tag;
                assign prev_g = 1'b1;
            end
            else
            begin : g_mid
                assign prev_t = tags[i-1];
                assign prev_g = ge[i-1];
            end
            if (i == QUEUE_DEPTH - 1)
            begin : g_last
                assign next_t = tags[i];
            end
            else
            begin : g_inner
                assign next_t = tags[i+1];
            end
            bpjq_cell u_cell (
                .clk      (clk),
                .ctrl     (ctrl),
                .new_tag  (new_tag),
                .prev_tag (prev_t),
                .next_tag (next_t),
                .prev_ge  (prev_g),
                .valid    (count_reg > CNT_W'(i)),
                .own_ge   (ge[i]),
                .tag      (tags[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            capacity_reg <= CAP_W'(16);
            shut_reg <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= accept;
            if (accept)
            begin
                count_reg <= count_next;
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_CAPACITY)
                begin
                    capacity_reg <= cfg_data;
                end
                else
                begin
                    shut_reg <= cfg_data[0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            out_tag_reg <= out_tag_next;
            now_empty_reg <= (count_next == '0);
        end
    end

    assign result_valid = result_valid_reg;
    assign status = status_reg;
    assign out_channel = out_tag_reg.chan;
    assign out_letter = out_tag_reg.ltr;
    assign out_has_sequence = out_tag_reg.hseq;
    assign out_sequence = out_tag_reg.seqv;
    assign now_empty = now_empty_reg;

endmodule

>>> rtl/core/bpjq_cell.sv
module bpjq_cell
    import bpjq_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  tag_t       new_tag,
    input  tag_t       prev_tag,
    input  tag_t       next_tag,
    input  logic       prev_ge,
    input  logic       valid,
    output logic       own_ge,
    output tag_t       tag
);

    tag_t tag_reg;
    tag_t tag_next;

    assign own_ge = valid && (tag_key(tag_reg) >= tag_key(new_tag));
    assign tag = tag_reg;

    always_comb
    begin
        tag_next = tag_reg;
        if (ctrl.pop)
        begin
            tag_next = next_tag;
        end
        else if (ctrl.push && !own_ge)
        begin
            if (prev_ge)
            begin
                tag_next = new_tag;
            end
            else
            begin
                tag_next = prev_tag;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
    end

endmodule

>>> rtl/core/bpjq_checker.sv
module bpjq_checker
    import bpjq_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        result_valid,
    input logic [2:0]  status,
    input logic [15:0] out_channel,
    input logic [7:0]  out_letter,
    input logic        out_has_sequence,
    input logic [15:0] out_sequence
);

    // every transfer gives exactly one result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> result_valid)
        else $error("missing result after transfer");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !result_valid)
        else $error("result without transfer");

    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status != ST_POPPED) |->
        (out_channel == '0 && out_letter == '0 && out_has_sequence == 1'b0
         && out_sequence == '0))
        else $error("payload not cleared");

    a_upper_case: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status == ST_POPPED) |-> !out_letter[5])
        else $error("popped letter not upper case");

endmodule

bind bounded_priority_job_queue bpjq_checker u_bpjq_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .result_valid     (result_valid),
    .status           (status),
    .out_channel      (out_channel),
    .out_letter       (out_letter),
    .out_has_sequence (out_has_sequence),
    .out_sequence     (out_sequence)
);
